// ===== src/ntc_tf_pkg.sv =====
// shared types and constants for the ntc adc to temperature glitch filter
// piecewise-linear table, status codes and register indexes; no dependencies
package ntc_tf_pkg;

  localparam int ADC_W      = 12;
  localparam int TEMP_W     = 11;
  localparam int GCNT_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int WIN_LOG2   = 2;
  localparam int WINDOW_LEN = 1 << WIN_LOG2;
  localparam int SUM_W      = TEMP_W + WIN_LOG2;

  localparam int NUM_SEG    = 5;
  localparam int SEG_IDX_W  = 3;
  localparam int SLOPE_W    = 8;
  localparam int PROD_W     = ADC_W + SLOPE_W;
  localparam int T_W        = ADC_W + 1;

  localparam logic [ADC_W-1:0] SEG_ADC [NUM_SEG] = '{
    12'd1101, 12'd2570, 12'd2877, 12'd3243, 12'd3502
  };
  localparam logic [ADC_W-1:0] SEG_TEMP [NUM_SEG] = '{
    12'd0, 12'd328, 12'd408, 12'd528, 12'd648
  };
  localparam logic [SLOPE_W-1:0] SEG_SLOPE [NUM_SEG] = '{
    8'd57, 8'd67, 8'd88, 8'd119, 8'd168
  };

  typedef logic [1:0] status_t;
  localparam status_t ADC_OK    = 2'd0;
  localparam status_t ADC_LOW   = 2'd1;
  localparam status_t ADC_HIGH  = 2'd2;
  localparam status_t TEMP_OK   = 2'd0;
  localparam status_t TEMP_LOW  = 2'd1;
  localparam status_t TEMP_HIGH = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_MIN         = 3'd0,
    REG_ADC_MAX         = 3'd1,
    REG_ADC_DEFAULT     = 3'd2,
    REG_TEMP_LOW_CLAMP  = 3'd3,
    REG_TEMP_HIGH_CLAMP = 3'd4,
    REG_JUMP_ZONE       = 3'd5,
    REG_GLITCH_LIMIT    = 3'd6
  } reg_idx_t;

  localparam logic [ADC_W-1:0]  RST_ADC_MIN         = 12'd0;
  localparam logic [ADC_W-1:0]  RST_ADC_MAX         = 12'd4095;
  localparam logic [ADC_W-1:0]  RST_ADC_DEFAULT     = 12'd2000;
  localparam logic [TEMP_W-1:0] RST_TEMP_LOW_CLAMP  = 11'd0;
  localparam logic [TEMP_W-1:0] RST_TEMP_HIGH_CLAMP = 11'd800;
  localparam logic [TEMP_W-1:0] RST_JUMP_ZONE       = 11'd40;
  localparam logic [GCNT_W-1:0] RST_GLITCH_LIMIT    = 4'd3;

endpackage

// ===== src/ntc_adc_to_temp_glitch_filter.sv =====
// top level of the ntc adc to temperature glitch filter
// input register, combinational convert and filter logic, result register
// depends on ntc_tf_pkg
//
// usage: one 12-bit thermistor sample per transfer on in_valid/in_stall with
// adc_sample; one result per sample on out_valid/out_stall with filtered_temp,
// adc_used, adc_status and temp_status. the user must write limits and clamps
// through cfg_valid/cfg_ready/cfg_index/cfg_data only while no sample is in flight;
// the block does not enforce this. cfg_ready is always high and an index beyond
// the register list is ignored. the sample lands in the input register, and range
// check, table lookup, glitch test and the four-entry average run combinationally
// into the result register together with the filter state, where out_valid marks
// the result. throughput is one sample per cycle while the receiver does not stall,
// set by the feedback of the running average through that single logic stage.
// when the receiver stalls, the result register holds and the input register
// keeps accepting until it is occupied; then in_stall rises.
// synchronous reset restores register defaults and empties both stages; the
// averaging window is loaded by the first sample after reset.
module ntc_adc_to_temp_glitch_filter
  import ntc_tf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADC_W-1:0]      adc_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TEMP_W-1:0]     filtered_temp,
  output logic [ADC_W-1:0]      adc_used,
  output logic [1:0]            adc_status,
  output logic [1:0]            temp_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [ADC_W-1:0]  adc_min, adc_max, adc_default;
  logic [TEMP_W-1:0] temp_low_clamp, temp_high_clamp, jump_zone;
  logic [GCNT_W-1:0] glitch_limit;

  // filter state
  logic [ADC_W-1:0]    last_good_adc;
  logic                seen_good;
  logic                started;
  logic [TEMP_W-1:0]   window [WINDOW_LEN];
  logic [TEMP_W-1:0]   last_average;
  logic [GCNT_W-1:0]   glitch_count;
  logic [WIN_LOG2-1:0] write_slot;

  // input register
  logic             in_q_valid;
  logic [ADC_W-1:0] sample_q;

  logic advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_min         <= RST_ADC_MIN;
      adc_max         <= RST_ADC_MAX;
      adc_default     <= RST_ADC_DEFAULT;
      temp_low_clamp  <= RST_TEMP_LOW_CLAMP;
      temp_high_clamp <= RST_TEMP_HIGH_CLAMP;
      jump_zone       <= RST_JUMP_ZONE;
      glitch_limit    <= RST_GLITCH_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ADC_MIN:         adc_min         <= cfg_data[ADC_W-1:0];
        REG_ADC_MAX:         adc_max         <= cfg_data[ADC_W-1:0];
        REG_ADC_DEFAULT:     adc_default     <= cfg_data[ADC_W-1:0];
        REG_TEMP_LOW_CLAMP:  temp_low_clamp  <= cfg_data[TEMP_W-1:0];
        REG_TEMP_HIGH_CLAMP: temp_high_clamp <= cfg_data[TEMP_W-1:0];
        REG_JUMP_ZONE:       jump_zone       <= cfg_data[TEMP_W-1:0];
        REG_GLITCH_LIMIT:    glitch_limit    <= cfg_data[GCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // range check
  logic [ADC_W-1:0] used;
  status_t          astat;
  always_comb begin
    if (sample_q < adc_min) begin
      astat = ADC_LOW;
      used  = seen_good ? last_good_adc : adc_default;
    end else if (sample_q > adc_max) begin
      astat = ADC_HIGH;
      used  = seen_good ? last_good_adc : adc_default;
    end else begin
      astat = ADC_OK;
      used  = sample_q;
    end
  end

  // piecewise-linear conversion
  logic [SEG_IDX_W-1:0] seg;
  logic [ADC_W-1:0]     seg_off;
  logic [PROD_W-1:0]    prod;
  logic [T_W-1:0]       t_raw;
  logic [TEMP_W-1:0]    temp;
  status_t              tstat;
  always_comb begin
    seg = '0;
    for (int i = 1; i < NUM_SEG; i++) begin
      if (used >= SEG_ADC[i]) seg = SEG_IDX_W'(i);
    end
    seg_off = used - SEG_ADC[seg];
    prod    = {{SLOPE_W{1'b0}}, seg_off} * {{ADC_W{1'b0}}, SEG_SLOPE[seg]};
    t_raw   = {1'b0, SEG_TEMP[seg]} + {1'b0, prod[PROD_W-1:SLOPE_W]};
    if (used < SEG_ADC[0]) begin
      tstat = TEMP_LOW;
      temp  = temp_low_clamp;
    end else if (t_raw > {{(T_W-TEMP_W){1'b0}}, temp_high_clamp}) begin
      tstat = TEMP_HIGH;
      temp  = temp_high_clamp;
    end else begin
      tstat = TEMP_OK;
      temp  = t_raw[TEMP_W-1:0];
    end
  end

  // glitch test and window average
  logic [TEMP_W-1:0]   avg_ref, diff, wr;
  logic [GCNT_W-1:0]   glitch_count_next;
  logic [TEMP_W-1:0]   win_next [WINDOW_LEN];
  logic [SUM_W-1:0]    sum;
  logic [TEMP_W-1:0]   average_next;
  logic [WIN_LOG2-1:0] write_slot_next;
  always_comb begin
    avg_ref = started ? last_average : temp;
    diff    = (temp > avg_ref) ? (temp - avg_ref) : (avg_ref - temp);
    glitch_count_next = glitch_count;
    if (diff > jump_zone) begin
      if (glitch_count < glitch_limit) begin
        glitch_count_next = glitch_count + GCNT_W'(1);
        wr = avg_ref;
      end else begin
        wr = temp;
      end
    end else begin
      glitch_count_next = '0;
      wr = temp;
    end
    sum = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (!started) win_next[i] = temp;
      else if (write_slot == WIN_LOG2'(i)) win_next[i] = wr;
      else win_next[i] = window[i];
      sum = sum + {{WIN_LOG2{1'b0}}, win_next[i]};
    end
    average_next    = sum[SUM_W-1:WIN_LOG2];
    write_slot_next = write_slot + WIN_LOG2'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid    <= 1'b0;
      out_valid     <= 1'b0;
      last_good_adc <= RST_ADC_DEFAULT;
      seen_good     <= 1'b0;
      started       <= 1'b0;
      last_average  <= '0;
      glitch_count  <= '0;
      write_slot    <= '0;
    end else begin
      if (!in_stall) in_q_valid <= in_valid;
      if (!out_valid || !out_stall) out_valid <= in_q_valid;
      if (advance) begin
        if (astat == ADC_OK) begin
          last_good_adc <= sample_q;
          seen_good     <= 1'b1;
        end
        started      <= 1'b1;
        last_average <= average_next;
        glitch_count <= glitch_count_next;
        write_slot   <= write_slot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) sample_q <= adc_sample;
    if (advance) begin
      for (int i = 0; i < WINDOW_LEN; i++) window[i] <= win_next[i];
      filtered_temp <= average_next;
      adc_used      <= used;
      adc_status    <= astat;
      temp_status   <= tstat;
    end
  end

endmodule

// ===== bench/ntc_tf_scoreboard_pkg.sv =====
// scoreboard for the ntc adc to temperature glitch filter: predicts each reading
// from the accepted samples and the register values, then checks the readings
// depends on ntc_tf_pkg
package ntc_tf_scoreboard_pkg;
  import ntc_tf_pkg::*;

  typedef struct packed {
    logic [TEMP_W-1:0] filtered_temp;
    logic [ADC_W-1:0]  adc_used;
    status_t           adc_status;
    status_t           temp_status;
  } reading_t;

  class ntc_filter_scoreboard;
    logic [ADC_W-1:0]  lo_limit, hi_limit, fallback_adc;
    logic [TEMP_W-1:0] low_clamp, high_clamp, zone;
    logic [GCNT_W-1:0] max_glitches;

    logic [ADC_W-1:0]  good_adc;
    bit                have_good, primed;
    logic [TEMP_W-1:0] taps [WINDOW_LEN];
    logic [TEMP_W-1:0] avg;
    logic [GCNT_W-1:0] glitches;
    int unsigned       slot;

    reading_t    expected_readings[$];
    int unsigned samples, readings, reg_writes, errors;
    int unsigned n_rejected, n_below_table, n_clamped, n_suppressed;

    function new();
      lo_limit     = RST_ADC_MIN;
      hi_limit     = RST_ADC_MAX;
      fallback_adc = RST_ADC_DEFAULT;
      low_clamp    = RST_TEMP_LOW_CLAMP;
      high_clamp   = RST_TEMP_HIGH_CLAMP;
      zone         = RST_JUMP_ZONE;
      max_glitches = RST_GLITCH_LIMIT;
      good_adc     = RST_ADC_DEFAULT;
      have_good    = 1'b0;
      primed       = 1'b0;
      foreach (taps[i]) taps[i] = '0;
      avg          = '0;
      glitches     = '0;
      slot         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_ADC_MIN:         lo_limit = data[ADC_W-1:0];
        REG_ADC_MAX:         hi_limit = data[ADC_W-1:0];
        REG_ADC_DEFAULT:     fallback_adc = data[ADC_W-1:0];
        REG_TEMP_LOW_CLAMP:  low_clamp = data[TEMP_W-1:0];
        REG_TEMP_HIGH_CLAMP: high_clamp = data[TEMP_W-1:0];
        REG_JUMP_ZONE:       zone = data[TEMP_W-1:0];
        REG_GLITCH_LIMIT:    max_glitches = data[GCNT_W-1:0];
        default: ;
      endcase
    endfunction

    // five-segment table lookup with both clamps
    function logic [TEMP_W-1:0] to_temp(logic [ADC_W-1:0] adc, output status_t st);
      logic [PROD_W-1:0] prod;
      logic [T_W-1:0]    t;
      int                s;
      if (adc < SEG_ADC[0]) begin
        st = TEMP_LOW;
        return low_clamp;
      end
      s = NUM_SEG - 1;
      while (s > 0 && adc < SEG_ADC[s]) s--;
      prod = PROD_W'(adc - SEG_ADC[s]) * PROD_W'(SEG_SLOPE[s]);
      t = T_W'(SEG_TEMP[s]) + T_W'(prod >> 8);
      if (t > T_W'(high_clamp)) begin
        st = TEMP_HIGH;
        return high_clamp;
      end
      st = TEMP_OK;
      return TEMP_W'(t);
    endfunction

    function void note_sample(logic [ADC_W-1:0] sample);
      reading_t          r;
      logic [TEMP_W-1:0] temp, diff, wr;
      logic [SUM_W-1:0]  sum;
      status_t           tst;
      samples++;
      if (sample < lo_limit) begin
        r.adc_status = ADC_LOW;
        r.adc_used   = have_good ? good_adc : fallback_adc;
      end else if (sample > hi_limit) begin
        r.adc_status = ADC_HIGH;
        r.adc_used   = have_good ? good_adc : fallback_adc;
      end else begin
        r.adc_status = ADC_OK;
        r.adc_used   = sample;
        good_adc     = sample;
        have_good    = 1'b1;
      end
      temp = to_temp(r.adc_used, tst);
      r.temp_status = tst;
      if (!primed) begin
        foreach (taps[i]) taps[i] = temp;
        avg    = temp;
        primed = 1'b1;
      end
      diff = (temp > avg) ? temp - avg : avg - temp;
      if (diff > zone) begin
        if (glitches < max_glitches) begin
          glitches++;
          wr = avg;
          n_suppressed++;
        end else begin
          wr = temp;
        end
      end else begin
        glitches = '0;
        wr = temp;
      end
      taps[slot] = wr;
      slot = (slot + 1) % WINDOW_LEN;
      sum = '0;
      foreach (taps[i]) sum += SUM_W'(taps[i]);
      avg = TEMP_W'(sum >> WIN_LOG2);
      r.filtered_temp = avg;
      if (r.adc_status != ADC_OK) n_rejected++;
      if (tst == TEMP_LOW) n_below_table++;
      if (tst == TEMP_HIGH) n_clamped++;
      expected_readings.push_back(r);
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      readings++;
      if (expected_readings.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("reading %0d with no sample pending: temp %0d used %0d st %0d/%0d",
                   readings, got.filtered_temp, got.adc_used, got.adc_status,
                   got.temp_status);
        return;
      end
      want = expected_readings.pop_front();
      if (got.filtered_temp !== want.filtered_temp || got.adc_used !== want.adc_used ||
          got.adc_status !== want.adc_status || got.temp_status !== want.temp_status) begin
        errors++;
        if (errors <= 10)
          $display("reading %0d mismatch: exp temp %0d used %0d st %0d/%0d, got temp %0d used %0d st %0d/%0d",
                   readings, want.filtered_temp, want.adc_used, want.adc_status,
                   want.temp_status, got.filtered_temp, got.adc_used, got.adc_status,
                   got.temp_status);
      end
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction
  endclass

endpackage

// ===== bench/tb.sv =====
// top-level bench for the ntc adc to temperature glitch filter: directed and
// random sample streams over several register settings with random stalls
// depends on ntc_tf_pkg, ntc_tf_scoreboard_pkg and the filter rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ntc_tf_pkg::*;
  import ntc_tf_scoreboard_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ADC_W-1:0] adc_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TEMP_W-1:0] filtered_temp;
  logic [ADC_W-1:0] adc_used;
  logic [1:0] adc_status, temp_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ntc_filter_scoreboard sb = new();
  reading_t seen;
  bit calm = 1'b0;
  int level = 2800;
  int spike_left = 0;
  int spike_ofs = 0;
  int unsigned quiet_cycles = 0;

  ntc_adc_to_temp_glitch_filter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .adc_sample(adc_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .filtered_temp(filtered_temp), .adc_used(adc_used),
    .adc_status(adc_status), .temp_status(temp_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 33);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.filtered_temp = filtered_temp;
      seen.adc_used      = adc_used;
      seen.adc_status    = adc_status;
      seen.temp_status   = temp_status;
      sb.check_reading(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic [ADC_W-1:0] s);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending and let every pending reading come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_all(input int amin, input int amax, input int adef, input int lowc,
                         input int highc, input int jz, input int glim);
    write_reg(REG_ADC_MIN, CFG_DATA_W'(amin));
    write_reg(REG_ADC_MAX, CFG_DATA_W'(amax));
    write_reg(REG_ADC_DEFAULT, CFG_DATA_W'(adef));
    write_reg(REG_TEMP_LOW_CLAMP, CFG_DATA_W'(lowc));
    write_reg(REG_TEMP_HIGH_CLAMP, CFG_DATA_W'(highc));
    write_reg(REG_JUMP_ZONE, CFG_DATA_W'(jz));
    write_reg(REG_GLITCH_LIMIT, CFG_DATA_W'(glim));
  endtask

  task automatic set_random();
    int amin, amax, highc, jz;
    amin  = ($urandom_range(99) < 15) ? 0 : ($urandom_range(99) < 6) ? 4095
          : int'($urandom_range(900));
    amax  = ($urandom_range(99) < 15) ? 4095 : ($urandom_range(99) < 6) ? 0
          : int'($urandom_range(4095, 3200));
    highc = ($urandom_range(99) < 10) ? 0 : ($urandom_range(99) < 10) ? 1100
          : int'($urandom_range(1100, 250));
    jz    = ($urandom_range(99) < 10) ? 0 : ($urandom_range(99) < 10) ? 1100
          : int'($urandom_range(150));
    set_all(amin, amax, int'($urandom_range(4095)), int'($urandom_range(1100)), highc, jz,
            int'($urandom_range(15)));
  endtask

  // mostly a slow walk around a level, with bursts of spikes and some noise
  function automatic logic [ADC_W-1:0] next_sample();
    int r;
    int v;
    r = $urandom_range(99);
    if (spike_left > 0) begin
      spike_left--;
      v = level + spike_ofs;
    end else if (r < 8) begin
      spike_left = $urandom_range(17);
      spike_ofs = $urandom_range(1) ? int'($urandom_range(1500, 30))
                                    : -int'($urandom_range(1500, 30));
      v = level + spike_ofs;
    end else if (r < 20) begin
      v = $urandom_range(4095);
    end else if (r < 22) begin
      level = $urandom_range(4095);
      v = level;
    end else begin
      level = level + int'($urandom_range(16)) - 8;
      if (level < 0) level = 0;
      if (level > 4095) level = 4095;
      v = level;
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return ADC_W'(v);
  endfunction

  initial begin
    int unsigned fails;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // rejects before any good sample, low clamp above high clamp, table breakpoints
    set_all(500, 3800, 1200, 1100, 800, 40, 3);
    write_reg(REG_UNUSED, 12'hfff);
    send_sample(12'd100);
    send_sample(12'd4000);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd1000);
    send_sample(12'd1100);
    send_sample(12'd1101);
    send_sample(12'd2569);
    send_sample(12'd2570);
    send_sample(12'd2876);
    send_sample(12'd2877);
    send_sample(12'd3243);
    send_sample(12'd3502);
    send_sample(12'd3800);
    send_sample(12'd3801);
    send_sample(12'd499);
    send_sample(12'd500);
    drain();
    // crossed limits reject everything, zero zone and zero glitch limit
    set_all(3000, 1000, 0, 0, 100, 0, 0);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd2000);
    send_sample(12'd3500);
    drain();
    // high clamp inside the first segment, widest zone, largest glitch limit
    set_all(0, 4095, 4095, 0, 100, 1100, 15);
    send_sample(12'd1500);
    send_sample(12'd2000);
    send_sample(12'd3502);
    send_sample(12'd0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 0) set_all(0, 4095, 2000, 0, 800, 40, 3);
      else if (p == 1) set_all(0, 4095, 0, 0, 1100, 0, 0);
      else set_random();
      calm = (p == 3);
      repeat (PHASE_ITEMS) send_sample(next_sample());
    end
    calm = 1'b0;
    drain();

    fails = sb.errors + sb.pending();
    $display("sent %0d samples, checked %0d readings, %0d register writes",
             sb.samples, sb.readings, sb.reg_writes);
    $display("range rejects %0d, below table %0d, clamped high %0d, glitches held %0d",
             sb.n_rejected, sb.n_below_table, sb.n_clamped, sb.n_suppressed);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ntc_tf_pkg.sv
src/ntc_adc_to_temp_glitch_filter.sv
bench/ntc_tf_scoreboard_pkg.sv
bench/tb.sv
